// ===== src/sst_pkg.sv =====
// Package: shared types, constants and the lexer step function of the source tokenizer.
`timescale 1ns / 1ps
package sst_pkg;

   localparam int OFFSET_BITS     = 20;
   localparam int KEYWORD_MAX_LEN = 6;
   localparam int WORD_BITS       = 8 * KEYWORD_MAX_LEN;
   localparam int WLEN_BITS       = $clog2(KEYWORD_MAX_LEN + 2);
   localparam int KIND_BITS       = 6;
   localparam int MAX_TOKENS      = 3;
   localparam int NUM_KEYWORDS    = 11;

   localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

   // token kinds
   localparam logic [KIND_BITS-1:0] K_LPAREN   = 6'd0;
   localparam logic [KIND_BITS-1:0] K_RPAREN   = 6'd1;
   localparam logic [KIND_BITS-1:0] K_LBRACKET = 6'd2;
   localparam logic [KIND_BITS-1:0] K_RBRACKET = 6'd3;
   localparam logic [KIND_BITS-1:0] K_LBRACE   = 6'd4;
   localparam logic [KIND_BITS-1:0] K_RBRACE   = 6'd5;
   localparam logic [KIND_BITS-1:0] K_COLON    = 6'd6;
   localparam logic [KIND_BITS-1:0] K_SEMI     = 6'd7;
   localparam logic [KIND_BITS-1:0] K_COMMA    = 6'd8;
   localparam logic [KIND_BITS-1:0] K_PLUS     = 6'd9;
   localparam logic [KIND_BITS-1:0] K_STAR     = 6'd10;
   localparam logic [KIND_BITS-1:0] K_PERCENT  = 6'd11;
   localparam logic [KIND_BITS-1:0] K_AT       = 6'd12;
   localparam logic [KIND_BITS-1:0] K_CARET    = 6'd13;
   localparam logic [KIND_BITS-1:0] K_DOT      = 6'd14;
   localparam logic [KIND_BITS-1:0] K_DOTBRACE = 6'd15;
   localparam logic [KIND_BITS-1:0] K_DOTBRACK = 6'd16;
   localparam logic [KIND_BITS-1:0] K_MINUS    = 6'd17;
   localparam logic [KIND_BITS-1:0] K_ARROW    = 6'd18;
   localparam logic [KIND_BITS-1:0] K_AND      = 6'd19;
   localparam logic [KIND_BITS-1:0] K_OR       = 6'd20;
   localparam logic [KIND_BITS-1:0] K_GT       = 6'd21;
   localparam logic [KIND_BITS-1:0] K_GE       = 6'd22;
   localparam logic [KIND_BITS-1:0] K_LT       = 6'd23;
   localparam logic [KIND_BITS-1:0] K_LE       = 6'd24;
   localparam logic [KIND_BITS-1:0] K_ASSIGN   = 6'd25;
   localparam logic [KIND_BITS-1:0] K_EQ       = 6'd26;
   localparam logic [KIND_BITS-1:0] K_BANG     = 6'd27;
   localparam logic [KIND_BITS-1:0] K_NE       = 6'd28;
   localparam logic [KIND_BITS-1:0] K_SLASH    = 6'd29;
   localparam logic [KIND_BITS-1:0] K_STRING   = 6'd30;
   localparam logic [KIND_BITS-1:0] K_INT      = 6'd31;
   localparam logic [KIND_BITS-1:0] K_FLOAT    = 6'd32;
   localparam logic [KIND_BITS-1:0] K_IDENT    = 6'd43;
   localparam logic [KIND_BITS-1:0] K_END      = 6'd44;

   // keywords, first character in the low byte
   localparam logic [47:0] KW_TEXT [NUM_KEYWORDS] = '{
      48'h6E66, 48'h7361, 48'h6E656C, 48'h636E7566, 48'h6669, 48'h65736C65,
      48'h656C696877, 48'h746375727473, 48'h6E7275746572, 48'h65757274,
      48'h65736C6166};
   localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
      4'd2, 4'd2, 4'd3, 4'd4, 4'd2, 4'd4, 4'd5, 4'd6, 4'd6, 4'd4, 4'd5};
   localparam logic [KIND_BITS-1:0] KW_KIND [NUM_KEYWORDS] = '{
      6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd42};

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_OP, MODE_INT, MODE_FRAC, MODE_WORD,
      MODE_STR, MODE_LINE, MODE_BLOCK, MODE_BSTAR
   } lex_mode_type;

   typedef struct packed {
      lex_mode_type           mode;
      logic [OFFSET_BITS-1:0] position;
      logic [OFFSET_BITS-1:0] token_begin;
      logic [OFFSET_BITS-1:0] line_count;
      logic [OFFSET_BITS-1:0] line_begin;
      logic [7:0]             held_byte;
      logic [WORD_BITS-1:0]   word_prefix;
      logic [WLEN_BITS-1:0]   word_length;
   } lex_state_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [OFFSET_BITS-1:0] start;
      logic [OFFSET_BITS-1:0] length;
      logic [OFFSET_BITS-1:0] line;
      logic [OFFSET_BITS-1:0] line_begin;
   } token_type;

   typedef struct packed {
      token_type [MAX_TOKENS-1:0] tok;
      logic [1:0]                 count;
   } token_list_type;

   typedef struct packed {
      lex_state_type  state;
      token_list_type list;
   } step_type;

   localparam lex_state_type LEX_RESET = '{
      mode: MODE_IDLE, position: '0, token_begin: '0,
      line_count: OFFSET_BITS'(1), line_begin: '0, held_byte: '0,
      word_prefix: '0, word_length: '0};

   function automatic logic [OFFSET_BITS-1:0] sat_inc(logic [OFFSET_BITS-1:0] v);
      return (v == OFF_MAX) ? OFF_MAX : v + OFFSET_BITS'(1);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
   endfunction

   // append a token unless the list is already full
   function automatic token_list_type push(token_list_type l, logic [KIND_BITS-1:0] kind,
                                           logic [OFFSET_BITS-1:0] start,
                                           logic [OFFSET_BITS-1:0] length,
                                           lex_state_type s);
      token_list_type r;
      r = l;
      if (l.count < 2'(MAX_TOKENS)) begin
         r.tok[l.count] = '{kind: kind, start: start, length: length,
                            line: s.line_count, line_begin: s.line_begin};
         r.count = l.count + 2'd1;
      end
      return r;
   endfunction

   function automatic logic single_kind(logic [7:0] c, output logic [KIND_BITS-1:0] k);
      logic ok;
      ok = 1'b1;
      case (c)
         "(": k = K_LPAREN;
         ")": k = K_RPAREN;
         "[": k = K_LBRACKET;
         "]": k = K_RBRACKET;
         "{": k = K_LBRACE;
         "}": k = K_RBRACE;
         ":": k = K_COLON;
         ";": k = K_SEMI;
         ",": k = K_COMMA;
         "+": k = K_PLUS;
         "*": k = K_STAR;
         "%": k = K_PERCENT;
         "@": k = K_AT;
         "^": k = K_CARET;
         default: begin
            k  = K_LPAREN;
            ok = 1'b0;
         end
      endcase
      return ok;
   endfunction

   function automatic logic op_alone(logic [7:0] h, output logic [KIND_BITS-1:0] k);
      logic ok;
      ok = 1'b1;
      case (h)
         ".": k = K_DOT;
         "-": k = K_MINUS;
         ">": k = K_GT;
         "<": k = K_LT;
         "=": k = K_ASSIGN;
         "!": k = K_BANG;
         "/": k = K_SLASH;
         default: begin
            k  = K_DOT;
            ok = 1'b0;
         end
      endcase
      return ok;
   endfunction

   function automatic logic op_pair(logic [7:0] h, logic [7:0] c,
                                    output logic [KIND_BITS-1:0] k);
      logic ok;
      ok = 1'b1;
      k  = K_DOTBRACE;
      if      (h == "." && c == "{") k = K_DOTBRACE;
      else if (h == "." && c == "[") k = K_DOTBRACK;
      else if (h == "-" && c == ">") k = K_ARROW;
      else if (h == "&" && c == "&") k = K_AND;
      else if (h == "|" && c == "|") k = K_OR;
      else if (h == ">" && c == "=") k = K_GE;
      else if (h == "<" && c == "=") k = K_LE;
      else if (h == "=" && c == "=") k = K_EQ;
      else if (h == "!" && c == "=") k = K_NE;
      else ok = 1'b0;
      return ok;
   endfunction

   function automatic logic [KIND_BITS-1:0] word_kind(lex_state_type s);
      logic [KIND_BITS-1:0] k;
      k = K_IDENT;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
         if ((32'(KW_LEN[i]) <= KEYWORD_MAX_LEN) &&
             (32'(KW_LEN[i]) == 32'(s.word_length)) &&
             (WORD_BITS'(KW_TEXT[i]) == s.word_prefix))
            k = KW_KIND[i];
      end
      return k;
   endfunction

   function automatic logic is_op_start(logic [7:0] c);
      return (c == ".") || (c == "-") || (c == "&") || (c == "|") || (c == ">") ||
             (c == "<") || (c == "=") || (c == "!") || (c == "/");
   endfunction

   // one input item: optional byte, then optional end of text
   function automatic step_type lex_step(lex_state_type s, logic [7:0] c,
                                         logic present, logic eot);
      step_type               r;
      lex_state_type          t;
      token_list_type         l;
      logic [OFFSET_BITS-1:0] p;
      logic [OFFSET_BITS-1:0] np;
      logic [KIND_BITS-1:0]   k;
      logic                   do_start;
      t        = s;
      l        = '0;
      p        = s.position;
      np       = sat_inc(s.position);
      do_start = 1'b0;
      if (present) begin
         case (t.mode)
            MODE_OP: begin
               if (t.held_byte == "/" && c == "/") t.mode = MODE_LINE;
               else if (t.held_byte == "/" && c == "*") t.mode = MODE_BLOCK;
               else if (op_pair(t.held_byte, c, k)) begin
                  l      = push(l, k, t.token_begin, np - t.token_begin, t);
                  t.mode = MODE_IDLE;
               end else begin
                  if (op_alone(t.held_byte, k))
                     l = push(l, k, t.token_begin, p - t.token_begin, t);
                  do_start = 1'b1;
               end
            end
            MODE_INT: begin
               if (c == ".") t.mode = MODE_FRAC;
               else if (!is_digit(c)) begin
                  l        = push(l, K_INT, t.token_begin, p - t.token_begin, t);
                  do_start = 1'b1;
               end
            end
            MODE_FRAC: begin
               if (!is_digit(c)) begin
                  l        = push(l, K_FLOAT, t.token_begin, p - t.token_begin, t);
                  do_start = 1'b1;
               end
            end
            MODE_WORD: begin
               if (is_alpha(c) || is_digit(c)) begin
                  if (32'(t.word_length) < KEYWORD_MAX_LEN)
                     t.word_prefix[{t.word_length, 3'b000} +: 8] = c;
                  if (32'(t.word_length) <= KEYWORD_MAX_LEN)
                     t.word_length = t.word_length + WLEN_BITS'(1);
               end else begin
                  l        = push(l, word_kind(t), t.token_begin, p - t.token_begin, t);
                  do_start = 1'b1;
               end
            end
            MODE_STR: begin
               if (c == "\"") begin
                  l      = push(l, K_STRING, t.token_begin, np - t.token_begin, t);
                  t.mode = MODE_IDLE;
               end else if (c == "\n") begin
                  t.line_count = sat_inc(t.line_count);
                  t.line_begin = np;
               end
            end
            MODE_LINE: begin
               if (c == "\n") begin
                  t.line_count = sat_inc(t.line_count);
                  t.line_begin = np;
                  t.mode       = MODE_IDLE;
               end
            end
            MODE_BLOCK: begin
               if (c == "*") t.mode = MODE_BSTAR;
               else if (c == "\n") begin
                  t.line_count = sat_inc(t.line_count);
                  t.line_begin = np;
               end
            end
            MODE_BSTAR: begin
               if (c == "/") t.mode = MODE_IDLE;
               else if (c == "\n") begin
                  t.line_count = sat_inc(t.line_count);
                  t.line_begin = np;
                  t.mode       = MODE_BLOCK;
               end else if (c != "*") t.mode = MODE_BLOCK;
            end
            default: do_start = 1'b1;
         endcase
         if (do_start) begin
            t.mode = MODE_IDLE;
            if (single_kind(c, k)) l = push(l, k, p, np - p, t);
            else if (is_op_start(c)) begin
               t.mode        = MODE_OP;
               t.held_byte   = c;
               t.token_begin = p;
            end else if (c == "\n") begin
               t.line_count = sat_inc(t.line_count);
               t.line_begin = np;
            end else if (c == "\"") begin
               t.mode        = MODE_STR;
               t.token_begin = p;
            end else if (is_digit(c)) begin
               t.mode        = MODE_INT;
               t.token_begin = p;
            end else if (is_alpha(c)) begin
               t.mode        = MODE_WORD;
               t.token_begin = p;
               t.word_prefix = WORD_BITS'(c);
               t.word_length = WLEN_BITS'(1);
            end
         end
         t.position = np;
      end
      if (eot) begin
         case (t.mode)
            MODE_OP: begin
               if (op_alone(t.held_byte, k))
                  l = push(l, k, t.token_begin, t.position - t.token_begin, t);
            end
            MODE_INT:  l = push(l, K_INT, t.token_begin, t.position - t.token_begin, t);
            MODE_FRAC: l = push(l, K_FLOAT, t.token_begin, t.position - t.token_begin, t);
            MODE_WORD: l = push(l, word_kind(t), t.token_begin,
                                t.position - t.token_begin, t);
            MODE_STR:  l = push(l, K_STRING, t.token_begin, t.position - t.token_begin, t);
            default: ;
         endcase
         l = push(l, K_END, t.position, '0, t);
         t = LEX_RESET;
      end
      r.state = t;
      r.list  = l;
      return r;
   endfunction

endpackage

// ===== src/sst_if.sv =====
// Interfaces: byte request channel and token response channel.
`timescale 1ns / 1ps
interface sst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       byte_present;
   logic       end_of_text;
   modport source (output valid, text_byte, byte_present, end_of_text, input ready);
   modport sink   (input valid, text_byte, byte_present, end_of_text, output ready);
endinterface

interface sst_rsp_if;
   logic                                         valid;
   logic                                         ready;
   logic [sst_pkg::KIND_BITS-1:0]                token_kind;
   logic [sst_pkg::OFFSET_BITS-1:0]              start_offset;
   logic [sst_pkg::OFFSET_BITS-1:0]              token_length;
   logic [sst_pkg::OFFSET_BITS-1:0]              line_number;
   logic [sst_pkg::OFFSET_BITS-1:0]              line_begin_offset;
   logic                                         run_last;
   modport source (output valid, token_kind, start_offset, token_length, line_number,
                   line_begin_offset, run_last, input ready);
   modport sink   (input valid, token_kind, start_offset, token_length, line_number,
                   line_begin_offset, run_last, output ready);
endinterface

// ===== src/sst_token_buffer.sv =====
// Token buffer: holds the up to three tokens of one transaction and hands them out in order.
`timescale 1ns / 1ps
module sst_token_buffer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  sst_pkg::token_list_type load_list,
   output logic                    can_load,
   input  logic                    out_ready,
   output logic                    out_valid,
   output sst_pkg::token_type      out_token,
   output logic                    out_last
);
   sst_pkg::token_type [sst_pkg::MAX_TOKENS-1:0] toks_ff, toks_in;
   logic [1:0] head_ff, head_in;
   logic [1:0] left_ff, left_in;
   logic       pop;

   assign out_valid = (left_ff != 2'd0);
   assign out_token = toks_ff[head_ff];
   assign out_last  = (left_ff == 2'd1);
   assign pop       = out_valid && out_ready;
   assign can_load  = (left_ff == 2'd0) || ((left_ff == 2'd1) && out_ready);

   always_comb begin
      toks_in = toks_ff;
      head_in = head_ff;
      left_in = left_ff;
      if (load) begin
         toks_in = load_list.tok;
         head_in = 2'd0;
         left_in = load_list.count;
      end else if (pop) begin
         head_in = head_ff + 2'd1;
         left_in = left_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      toks_ff <= toks_in;
      if (reset) begin
         head_ff <= 2'd0;
         left_ff <= 2'd0;
      end else begin
         head_ff <= head_in;
         left_ff <= left_in;
      end
   end
endmodule

// ===== src/script_source_tokenizer.sv =====
// Top level: streaming source tokenizer, one text byte per transaction.
`timescale 1ns / 1ps
// Takes source text one byte per request transaction and emits tokens on the
// response channel. A request may carry a byte, an end-of-text mark, or both;
// it produces zero to three token transactions, the last flagged by run_last.
// The lexer state (mode, position, line count, held operator byte, keyword
// prefix) is registered and updates on each accepted request, so a request
// is taken every cycle as long as each request yields at most one token and
// the response side keeps up. A request with several tokens holds the response
// buffer until its last token leaves, and the next request is taken in the
// cycle that token leaves. The first token appears in the cycle after its request is taken.
// After end of text the block returns to its reset state, ready for a new text.
module script_source_tokenizer (
   input logic        clock,
   input logic        reset,
   sst_req_if.sink    req,
   sst_rsp_if.source  rsp
);
   sst_pkg::lex_state_type state_ff, state_in;
   sst_pkg::step_type      step;
   sst_pkg::token_type     tok;
   logic                   can_load;
   logic                   accept;

   // one byte and/or end mark through the lexer
   assign step   = sst_pkg::lex_step(state_ff, req.text_byte, req.byte_present,
                                     req.end_of_text);
   assign req.ready = can_load;
   assign accept = req.valid && can_load;

   // advance lexer state only on an accepted transaction
   assign state_in = accept ? step.state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= sst_pkg::LEX_RESET;
      else       state_ff <= state_in;
   end

   sst_token_buffer u_buffer (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_list (step.list),
      .can_load  (can_load),
      .out_ready (rsp.ready),
      .out_valid (rsp.valid),
      .out_token (tok),
      .out_last  (rsp.run_last)
   );

   assign rsp.token_kind        = tok.kind;
   assign rsp.start_offset      = tok.start;
   assign rsp.token_length      = tok.length;
   assign rsp.line_number       = tok.line;
   assign rsp.line_begin_offset = tok.line_begin;
endmodule

// ===== src/sst_checker.sv =====
// Checker: port-level assertions for the source tokenizer, bound to the top level.
`timescale 1ns / 1ps
module sst_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_end_of_text,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [sst_pkg::KIND_BITS-1:0]       rsp_token_kind,
   input logic [sst_pkg::OFFSET_BITS-1:0]     rsp_line_number,
   input logic                                rsp_run_last
);
   // hold a stalled token
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind))
      else $error("stalled token changed");

   // end of text always yields at least the end token
   a_eot_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end_of_text |=> rsp_valid)
      else $error("no token after end of text");

   // the end token closes its run
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == sst_pkg::K_END) |-> rsp_run_last)
      else $error("end token not last");

   // lines count from one
   a_line_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_number != '0))
      else $error("line number zero");
endmodule

bind script_source_tokenizer sst_checker u_sst_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .req_end_of_text (req.end_of_text),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_token_kind  (rsp.token_kind),
   .rsp_line_number (rsp.line_number),
   .rsp_run_last    (rsp.run_last)
);
